// File: hdl/ipmc_pkg.sv
// Shared types, constants and helpers for the IPv4 rule match counter.
// Used by ipmc_cell, ip_rule_match_counter_core and the testbench; depends on nothing else.
package ipmc_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_RULES = 64;
   localparam int STORED_W  = $clog2(MAX_RULES + 1);
   localparam int ADDR_W    = 32;
   localparam int PLEN_W    = 6;
   localparam int COUNT_W   = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Request opcodes; the first three double as the stored rule kind.
   typedef enum logic [1:0] {
      OP_EXACT  = 2'd0,
      OP_RANGE  = 2'd1,
      OP_PREFIX = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   // One stored rule: address or range start, then range end or prefix mask.
   typedef struct packed {
      opcode_type        kind;
      logic [ADDR_W-1:0] first_word;
      logic [ADDR_W-1:0] second_word;
   } rule_type;

   // A query word travelling down the cell chain with its running count.
   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] count;
   } token_type;

   // Network mask for a prefix length; zero gives an empty mask, and
   // anything above the address width gives a full mask.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] mask;
      if (plen == '0) begin
         mask = '0;
      end else if (plen >= PLEN_W'(ADDR_W)) begin
         mask = '1;
      end else begin
         mask = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - plen);
      end
      return mask;
   endfunction

endpackage

// File: hdl/ip_rule_match_counter_core.sv
// Top level of the IPv4 rule match counter: cell chain, insert logic and result register.
// Depends on ipmc_pkg and ipmc_cell.
//
//   Channel   Direction  Handshake           Word contents
//   req_      in         req_valid/stall     opcode, address_a, address_b, prefix_length
//   rsp_      out        rsp_valid/stall     match_count, insert_rejected
//
// An insert writes the next free cell; its result is ready the cycle after acceptance.
// A query walks the chain of MAX_RULES cells, one cell a cycle, and its result is then
// registered at the output; one item is in flight at a time.
// Synchronous reset empties the table and drops any word in flight.
// A stalled result holds in the output register; a new request is taken in the cycle
// that result leaves.
module ip_rule_match_counter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_opcode,
   input  logic [ipmc_pkg::ADDR_W-1:0]    req_address_a,
   input  logic [ipmc_pkg::ADDR_W-1:0]    req_address_b,
   input  logic [ipmc_pkg::PLEN_W-1:0]    req_prefix_length,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ipmc_pkg::COUNT_W-1:0]   rsp_match_count,
   output logic                           rsp_insert_rejected
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                        state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ipmc_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                             rsp_rej_ff, rsp_rej_in;
   logic [ipmc_pkg::STORED_W-1:0]    stored_ff, stored_in;

   ipmc_pkg::opcode_type             op;
   logic                             req_accept;
   logic                             ins_accept;
   logic                             table_full;
   ipmc_pkg::rule_type               new_rule;
   ipmc_pkg::token_type              tok [ipmc_pkg::MAX_RULES+1];
   logic [ipmc_pkg::MAX_RULES-1:0]   cell_wr;
   logic [ipmc_pkg::MAX_RULES-1:0]   cell_live;

   assign op         = ipmc_pkg::opcode_type'(req_opcode);
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign ins_accept = req_accept && (op != ipmc_pkg::OP_QUERY);
   assign table_full = (stored_ff >= ipmc_pkg::STORED_W'(ipmc_pkg::MAX_RULES));

   // Build the rule word for an insert; exact rules keep a zero second word.
   always_comb begin
      new_rule.kind       = op;
      new_rule.first_word = req_address_a;
      case (op)
         ipmc_pkg::OP_RANGE: begin
            new_rule.second_word = req_address_b;
         end
         ipmc_pkg::OP_PREFIX: begin
            new_rule.second_word = ipmc_pkg::prefix_mask(req_prefix_length);
         end
         default: begin
            new_rule.second_word = '0;
         end
      endcase
   end

   // A query enters the head of the chain with a zero count.
   always_comb begin
      tok[0].valid   = req_accept && (op == ipmc_pkg::OP_QUERY);
      tok[0].address = req_address_a;
      tok[0].count   = '0;
   end

   // The chain of cells; each one knows whether it holds a stored rule.
   for (genvar i = 0; i < ipmc_pkg::MAX_RULES; i++) begin : g_cell
      assign cell_live[i] = (ipmc_pkg::STORED_W'(i) < stored_ff);
      assign cell_wr[i]   = ins_accept && (stored_ff == ipmc_pkg::STORED_W'(i));

      ipmc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (cell_wr[i]),
         .wr_rule (new_rule),
         .live    (cell_live[i]),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   // Next state, fill count and result register.
   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tok[0].valid) begin
               state_in = ST_SCAN;
            end
            if (ins_accept) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = '0;
               rsp_rej_in   = table_full;
               if (!table_full) begin
                  stored_in = stored_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (tok[ipmc_pkg::MAX_RULES].valid) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = tok[ipmc_pkg::MAX_RULES].count;
               rsp_rej_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_count     = rsp_count_ff;
   assign rsp_insert_rejected = rsp_rej_ff;

endmodule

// File: hdl/ipmc_cell.sv
// One cell of the rule chain: holds one rule and tests the passing query word.
// Depends on ipmc_pkg for the rule and token types.
module ipmc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  ipmc_pkg::rule_type  wr_rule,
   input  logic                live,
   input  ipmc_pkg::token_type tok_in,
   output ipmc_pkg::token_type tok_out
);

   ipmc_pkg::rule_type  rule_ff;
   ipmc_pkg::token_type tok_ff;
   ipmc_pkg::token_type tok_in_d;
   logic                hit;

   // Compare the passing address against the stored rule.
   always_comb begin
      case (rule_ff.kind)
         ipmc_pkg::OP_EXACT: begin
            hit = (tok_in.address == rule_ff.first_word);
         end
         ipmc_pkg::OP_RANGE: begin
            hit = (tok_in.address >= rule_ff.first_word) &&
                  (tok_in.address <= rule_ff.second_word);
         end
         ipmc_pkg::OP_PREFIX: begin
            hit = ((tok_in.address & rule_ff.second_word) ==
                   (rule_ff.first_word & rule_ff.second_word));
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // Bump the count, saturating, when this cell holds a stored rule that hits.
   always_comb begin
      tok_in_d = tok_in;
      if (live && hit && (tok_in.count != ipmc_pkg::COUNT_MAX)) begin
         tok_in_d.count = tok_in.count + 1'b1;
      end
   end

   // Rule storage is written once per insert and needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_ff <= wr_rule;
      end
   end

   // Hand the query word to the next cell every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_d.valid;
      end
      tok_ff.address <= tok_in_d.address;
      tok_ff.count   <= tok_in_d.count;
   end

   assign tok_out = tok_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for ip_rule_match_counter_core: directed and random request words,
// a predictor that keeps its own rule table, and phases of sender idling and receiver stalls.
// Depends on ipmc_pkg and ip_rule_match_counter_core.
module testbench;
   import ipmc_pkg::*;

   // One request word waiting to be driven, with the idling pattern of its phase.
   typedef struct {
      opcode_type         op;
      logic [ADDR_W-1:0]  addr_a;
      logic [ADDR_W-1:0]  addr_b;
      logic [PLEN_W-1:0]  plen;
      int unsigned        send_idle_pct;
      int unsigned        recv_stall_pct;
      bit                 drain_first;
   } request_word_type;

   // One predicted response word.
   typedef struct {
      logic [COUNT_W-1:0] match_count;
      logic               insert_rejected;
   } outcome_type;

   localparam int PHASES         = 4;
   localparam int ITEMS_PER_PHASE = 220;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_opcode = '0;
   logic [ADDR_W-1:0]    req_address_a = '0;
   logic [ADDR_W-1:0]    req_address_b = '0;
   logic [PLEN_W-1:0]    req_prefix_length = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COUNT_W-1:0]   rsp_match_count;
   logic                 rsp_insert_rejected;

   request_word_type     pending_requests[$];
   outcome_type          expected_outcomes[$];
   bit                   req_fire = 1'b0;
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_stall_pct = 0;
   int                   fail_count = 0;

   // Predictor copy of the rule table.
   opcode_type           tab_kind  [MAX_RULES];
   logic [ADDR_W-1:0]    tab_base  [MAX_RULES];
   logic [ADDR_W-1:0]    tab_limit [MAX_RULES];
   int                   tab_fill = 0;

   // Stimulus bookkeeping: addresses worth probing and the phase being generated.
   logic [ADDR_W-1:0]    probe_addrs[$];
   logic [ADDR_W-1:0]    hot_addr;
   int unsigned          gen_idle = 0;
   int unsigned          gen_stall = 0;
   bit                   gen_drain = 1'b0;
   int                   inserts_made = 0;
   int unsigned          idle_by_phase  [PHASES] = '{0, 50, 0, 29};
   int unsigned          stall_by_phase [PHASES] = '{0, 0, 50, 29};

   ip_rule_match_counter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_address_a       (req_address_a),
      .req_address_b       (req_address_b),
      .req_prefix_length   (req_prefix_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_match_count     (rsp_match_count),
      .rsp_insert_rejected (rsp_insert_rejected)
   );

   always #1 clock = ~clock;

   // Apply one request word to the predicted table and return the response it should give.
   function automatic outcome_type classify_request(input request_word_type w);
      outcome_type       res;
      logic [PLEN_W-1:0] len;
      logic [ADDR_W-1:0] mask;
      bit                hit;
      int                i;
      res.match_count = '0;
      res.insert_rejected = 1'b0;
      if (w.op == OP_QUERY) begin
         for (i = 0; i < tab_fill; i++) begin
            case (tab_kind[i])
               OP_EXACT: begin
                  hit = (w.addr_a == tab_base[i]);
               end
               OP_RANGE: begin
                  hit = (w.addr_a >= tab_base[i]) && (w.addr_a <= tab_limit[i]);
               end
               default: begin
                  hit = ((w.addr_a ^ tab_base[i]) & tab_limit[i]) == '0;
               end
            endcase
            if (hit && res.match_count != COUNT_MAX) begin
               res.match_count = res.match_count + 1'b1;
            end
         end
      end else if (tab_fill >= MAX_RULES) begin
         res.insert_rejected = 1'b1;
      end else begin
         // Lengths past the address width saturate; shifting all ones right by the
         // length leaves the host bits, so its inverse is the network mask.
         len  = (w.plen > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : w.plen;
         mask = ~({ADDR_W{1'b1}} >> len);
         tab_kind[tab_fill] = w.op;
         tab_base[tab_fill] = w.addr_a;
         case (w.op)
            OP_RANGE: begin
               tab_limit[tab_fill] = w.addr_b;
            end
            OP_PREFIX: begin
               tab_limit[tab_fill] = mask;
            end
            default: begin
               tab_limit[tab_fill] = '0;
            end
         endcase
         tab_fill++;
      end
      return res;
   endfunction

   // Queue one request word and remember the addresses near its rule boundaries.
   task automatic add_request(input opcode_type op, input logic [ADDR_W-1:0] a,
                              input logic [ADDR_W-1:0] b, input logic [PLEN_W-1:0] plen);
      request_word_type w;
      w.op = op;
      w.addr_a = a;
      w.addr_b = b;
      w.plen = plen;
      w.send_idle_pct = gen_idle;
      w.recv_stall_pct = gen_stall;
      w.drain_first = gen_drain;
      gen_drain = 1'b0;
      pending_requests.insert(pending_requests.size(), w);
      if (op != OP_QUERY) begin
         inserts_made++;
         probe_addrs.insert(probe_addrs.size(), a);
         probe_addrs.insert(probe_addrs.size(), a - 1'b1);
         probe_addrs.insert(probe_addrs.size(), a + 1'b1);
         if (op == OP_RANGE) begin
            probe_addrs.insert(probe_addrs.size(), b);
            probe_addrs.insert(probe_addrs.size(), b + 1'b1);
         end
      end
   endtask

   // Driver: presents the next word once the previous one is taken, idling at random.
   always @(negedge clock) begin
      request_word_type w;
      logic             present;
      if (!reset) begin
         if (!req_valid || req_fire) begin
            present = 1'b0;
            if (pending_requests.size() != 0 &&
                !(pending_requests[0].drain_first && expected_outcomes.size() != 0)) begin
               send_idle_pct = pending_requests[0].send_idle_pct;
               recv_stall_pct = pending_requests[0].recv_stall_pct;
               if ($urandom_range(99) >= send_idle_pct) begin
                  w = pending_requests.pop_front();
                  req_opcode <= w.op;
                  req_address_a <= w.addr_a;
                  req_address_b <= w.addr_b;
                  req_prefix_length <= w.plen;
                  present = 1'b1;
               end
            end
            req_valid <= present;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: checks each response word against the oldest prediction, then predicts
   // for any request word taken at this edge.
   always @(posedge clock) begin
      outcome_type      want;
      request_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $error("unexpected response word: match_count %0d insert_rejected %0d",
                      rsp_match_count, rsp_insert_rejected);
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_match_count !== want.match_count) begin
                  $error("match_count mismatch: expected %0d, actual %0d",
                         want.match_count, rsp_match_count);
                  fail_count++;
               end
               if (rsp_insert_rejected !== want.insert_rejected) begin
                  $error("insert_rejected mismatch: expected %0d, actual %0d",
                         want.insert_rejected, rsp_insert_rejected);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            w.op = opcode_type'(req_opcode);
            w.addr_a = req_address_a;
            w.addr_b = req_address_b;
            w.plen = req_prefix_length;
            expected_outcomes.insert(expected_outcomes.size(), classify_request(w));
         end
      end
      req_fire <= !reset && req_valid && !req_stall;
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] host;
      logic [PLEN_W-1:0] plen;
      opcode_type        op;
      int unsigned       roll;
      bit                near;
      hot_addr = $urandom();

      // Directed words: empty-table query, address extremes, every rule kind, an inverted
      // range, prefix lengths of zero, full width and beyond, then probing queries.
      add_request(OP_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 6'd63);
      add_request(OP_EXACT,  32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
      add_request(OP_EXACT,  32'h0000_0000, 32'hFFFF_FFFF, 6'd63);
      add_request(OP_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
      add_request(OP_RANGE,  32'hC0A8_0105, 32'hC0A8_0100, 6'd17);
      add_request(OP_PREFIX, $urandom(),    32'h0000_0000, 6'd0);
      add_request(OP_PREFIX, 32'hC0A8_0101, 32'h5555_5555, 6'd32);
      add_request(OP_PREFIX, 32'hC0A8_0101, 32'hAAAA_AAAA, 6'd63);
      add_request(OP_PREFIX, 32'hC0A8_01FF, 32'h0000_0000, 6'd33);
      add_request(OP_PREFIX, 32'hC0A8_0100, 32'hFFFF_FFFF, 6'd24);
      add_request(OP_PREFIX, 32'h8000_0000, 32'h0000_0000, 6'd1);
      add_request(OP_RANGE,  32'hC0A8_0100, 32'hC0A8_01FF, 6'd42);
      add_request(OP_QUERY,  32'h0000_0000, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32);
      add_request(OP_QUERY,  32'hC0A8_0101, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hC0A8_0100, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hC0A8_0102, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hC0A8_0105, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'h7FFF_FFFF, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hC0A8_0200, 32'h0000_0000, 6'd0);
      add_request(OP_QUERY,  32'hC0A8_01FF, 32'h0000_0000, 6'd0);

      // Random phases; each starts only once every earlier response has arrived.
      for (int p = 0; p < PHASES; p++) begin
         gen_idle = idle_by_phase[p];
         gen_stall = stall_by_phase[p];
         gen_drain = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(99);
            if (roll < ((inserts_made < MAX_RULES) ? 50 : 20)) begin
               // Most rules cover the hot address so that counts climb high.
               op = opcode_type'($urandom_range(2));
               near = ($urandom_range(99) < 70);
               a = $urandom();
               b = $urandom();
               plen = PLEN_W'($urandom_range(63));
               case (op)
                  OP_EXACT: begin
                     if (near) a = hot_addr;
                  end
                  OP_RANGE: begin
                     if (near) begin
                        a = hot_addr - $urandom_range(300);
                        b = hot_addr + $urandom_range(300);
                     end else if ($urandom_range(1) != 0) begin
                        b = a + $urandom_range(1000);
                     end
                  end
                  default: begin
                     host = $urandom();
                     if (near) a = hot_addr ^ (host >> plen);
                  end
               endcase
               add_request(op, a, b, plen);
            end else begin
               roll = $urandom_range(99);
               if (roll < 30) begin
                  a = hot_addr;
               end else if (roll < 45) begin
                  a = $urandom();
               end else if (roll < 50) begin
                  a = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
               end else begin
                  a = probe_addrs[$urandom_range(probe_addrs.size() - 1)];
               end
               add_request(OP_QUERY, a, $urandom(), PLEN_W'($urandom_range(63)));
            end
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every word to be taken and answered, then leave room for a stray response.
      while (pending_requests.size() != 0 || expected_outcomes.size() != 0 ||
             (req_valid && !req_fire)) begin
         @(negedge clock);
      end
      repeat (MAX_RULES + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: ip_rule_match_counter_core.f
hdl/ipmc_pkg.sv
hdl/ipmc_cell.sv
hdl/ip_rule_match_counter_core.sv
tb/testbench.sv
